>>> rtl/cbsm_pkg.sv
// shared types, constants and the log2 fraction table builder for the
// channel busy and sinr window monitor; no dependencies
`default_nettype none

package cbsm_pkg;

	// field widths
	localparam int TIME_BITS  = 48;
	localparam int COUNT_BITS = 16;
	localparam int SINR_BITS  = 32;
	localparam int WLEN_BITS  = 32;
	localparam int DB_BITS    = 16;
	localparam int UTIL_BITS  = 17;
	localparam int SUM_BITS   = 32;
	localparam int FRAC_BITS  = 16;

	// stream packing
	localparam int S_DATA_BITS = 88;
	localparam int S_USER_BITS = 2;
	localparam int M_DATA_BITS = 56;
	localparam int M_USER_BITS = 1;

	// configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [0:0] REG_WLEN = 1'b0;
	localparam logic [WLEN_BITS-1:0] WLEN_RESET = 32'd1000000;

	// input action codes
	localparam logic [1:0] ACTION_BUSY = 2'd0;
	localparam logic [1:0] ACTION_SINR = 2'd1;
	localparam logic [1:0] ACTION_WEND = 2'd2;

	// log table and db conversion
	localparam int LOG_ENTRIES = 64;
	localparam int IDX_BITS    = $clog2(LOG_ENTRIES);
	localparam int LOFF_BITS   = 25;
	localparam int PROD_BITS   = 43;
	localparam int DBW_BITS    = 21;
	localparam logic [17:0] DB_PER_LOG2 = 18'd197283;
	localparam logic [8:0]  EXP_OFFSET  = 9'd240;

	// window statistics
	localparam logic signed [DB_BITS-1:0] DB_INF = 16'sd32767;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [UTIL_BITS-1:0] UTIL_FULL = 17'h10000;

	// iterative divider
	localparam int DIV_BITS = WLEN_BITS + FRAC_BITS;
	localparam int DEN_BITS = 32;
	localparam int DCNT_BITS = $clog2(DIV_BITS);

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		KIND_BUSY,
		KIND_SINR,
		KIND_WEND
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [TIME_BITS-1:0]       now_time;
		logic                       busy_level;
		logic signed [DB_BITS-1:0]  db;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef logic [LOG_ENTRIES-1:0][FRAC_BITS-1:0] log_tab_t;

	// log2(1 + i/entries) in q0.16, truncated, by repeated squaring
	function automatic log_tab_t build_log_tab();
		log_tab_t          tab;
		logic [63:0]       y;
		logic [FRAC_BITS-1:0] acc;
		tab = '0;
		for (int i = 0; i < LOG_ENTRIES; i++) begin
			y = (64'd1 << 31) + (64'(i) << (31 - IDX_BITS));
			acc = '0;
			for (int b = FRAC_BITS - 1; b >= 0; b--) begin
				y = (y * y) >> 31;
				if (y >= (64'd1 << 32)) begin
					acc[b] = 1'b1;
					y = y >> 1;
				end
			end
			tab[i] = acc;
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

>>> rtl/cbsm_div.sv
// restoring divider, one quotient bit per cycle
// depends on cbsm_pkg
`default_nettype none

module cbsm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cbsm_pkg::DIV_BITS-1:0] dividend,
	input  wire logic [cbsm_pkg::DEN_BITS-1:0] divisor,
	output logic                               busy,
	output logic [cbsm_pkg::DIV_BITS-1:0]      quotient
);
	import cbsm_pkg::*;

	logic [DEN_BITS-1:0]  rem_q;
	logic [DIV_BITS-1:0]  quo_q;
	logic [DEN_BITS-1:0]  den_q;
	logic [DCNT_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic [DEN_BITS:0]    trial;
	logic [DEN_BITS:0]    diff;
	logic                 ge;

	always_comb begin
		trial = {rem_q, quo_q[DIV_BITS-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= dividend;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
			quo_q <= {quo_q[DIV_BITS-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_BITS'(DIV_BITS - 1))
				busy_q <= 1'b0;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/cbsm_front.sv
// front end: accepts input beats, drops ignored ones, converts sinr to db
// depends on cbsm_pkg
`default_nettype none

module cbsm_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [cbsm_pkg::S_DATA_BITS-1:0] s_tdata,
	input  wire logic [cbsm_pkg::S_USER_BITS-1:0] s_tuser,
	input  wire cbsm_pkg::qstat_t                 qstat,
	output logic                                  push,
	output cbsm_pkg::item_t                       item
);
	import cbsm_pkg::*;

	localparam log_tab_t LOG_TAB = build_log_tab();

	logic                  front_en;
	logic                  take;
	logic [1:0]            action;
	logic [TIME_BITS-1:0]  in_now;
	logic                  in_level;
	logic [SINR_BITS-1:0]  in_sinr;
	logic                  keep;
	kind_t                 in_kind;

	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [TIME_BITS-1:0]  now_s1;
	logic                  level_s1;
	logic [SINR_BITS-1:0]  sinr_s1;

	logic                  valid_s2;
	kind_t                 kind_s2;
	logic [TIME_BITS-1:0]  now_s2;
	logic                  level_s2;
	logic [LOFF_BITS-1:0]  loff_s2;

	logic                  valid_s3;
	kind_t                 kind_s3;
	logic [TIME_BITS-1:0]  now_s3;
	logic                  level_s3;
	logic [PROD_BITS-1:0]  prod_s3;

	logic [4:0]            lead;
	logic [SINR_BITS-1:0]  norm;
	logic [IDX_BITS-1:0]   idx;
	logic [8:0]            expo;
	logic [LOFF_BITS-1:0]  loff;
	logic [PROD_BITS:0]    rnd;
	logic [DBW_BITS-1:0]   dbw;

	// whole pipe moves unless the last stage is stuck on a full queue
	assign front_en = !valid_s3 || !qstat.full;
	assign s_tready = front_en;
	assign take     = s_tvalid && front_en;

	// tdata: now_time, busy_level, linear_sinr; tuser: action
	assign in_now   = s_tdata[TIME_BITS-1:0];
	assign in_level = s_tdata[TIME_BITS];
	assign in_sinr  = s_tdata[TIME_BITS+SINR_BITS:TIME_BITS+1];
	assign action   = s_tuser;

	always_comb begin
		keep    = 1'b0;
		in_kind = KIND_BUSY;
		unique case (action)
			ACTION_BUSY: begin
				keep    = 1'b1;
				in_kind = KIND_BUSY;
			end
			ACTION_SINR: begin
				keep    = in_sinr != '0;
				in_kind = KIND_SINR;
			end
			ACTION_WEND: begin
				keep    = 1'b1;
				in_kind = KIND_WEND;
			end
			default: begin
				keep    = 1'b0;
				in_kind = KIND_BUSY;
			end
		endcase
	end

	// leading one, normalize, table lookup
	always_comb begin
		lead = '0;
		for (int b = 0; b < SINR_BITS; b++)
			if (sinr_s1[b])
				lead = 5'(b);
		norm = sinr_s1 << (5'd31 - lead);
		idx  = norm[SINR_BITS-2 -: IDX_BITS];
		expo = 9'(lead) + EXP_OFFSET;
		loff = {expo, {FRAC_BITS{1'b0}}} + LOFF_BITS'(LOG_TAB[idx]);
	end

	// round the q11.32 product down to q8.8 and remove the offset
	always_comb begin
		rnd = {1'b0, prod_s3} + (PROD_BITS+1)'(64'd1 << 23);
		dbw = DBW_BITS'(rnd[PROD_BITS:24]) - DBW_BITS'(DB_PER_LOG2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (front_en) begin
			valid_s1 <= take && keep;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			kind_s1  <= in_kind;
			now_s1   <= in_now;
			level_s1 <= in_level;
			sinr_s1  <= in_sinr;
			kind_s2  <= kind_s1;
			now_s2   <= now_s1;
			level_s2 <= level_s1;
			loff_s2  <= loff;
			kind_s3  <= kind_s2;
			now_s3   <= now_s2;
			level_s3 <= level_s2;
			prod_s3  <= PROD_BITS'(loff_s2) * PROD_BITS'(DB_PER_LOG2);
		end
	end

	assign push            = valid_s3 && !qstat.full;
	assign item.kind       = kind_s3;
	assign item.now_time   = now_s3;
	assign item.busy_level = level_s3;
	assign item.db         = dbw[DB_BITS-1:0];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!front_en |=> valid_s3 && $stable(prod_s3) && $stable(now_s3))
		else $error("front pipe moved during a queue stall");

endmodule

`default_nettype wire

>>> rtl/cbsm_queue.sv
// short register queue between the front and back ends
// depends on cbsm_pkg
`default_nettype none

module cbsm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cbsm_pkg::item_t wr_item,
	input  wire logic            pop,
	output cbsm_pkg::item_t      rd_item,
	output cbsm_pkg::qstat_t     qstat
);
	import cbsm_pkg::*;

	item_t                entry_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_item;
	end

	assign rd_item     = entry_q[rd_ptr_q];
	assign qstat.full  = cnt_q == (QPTR_BITS+1)'(QDEPTH);
	assign qstat.empty = cnt_q == '0;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/cbsm_back.sv
// back end: busy time and sinr statistics, window end division and result register
// depends on cbsm_pkg and cbsm_div
`default_nettype none

module cbsm_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [cbsm_pkg::WLEN_BITS-1:0] wlen,
	input  wire cbsm_pkg::item_t                item,
	input  wire cbsm_pkg::qstat_t               qstat,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [cbsm_pkg::M_DATA_BITS-1:0]    m_tdata,
	output logic [cbsm_pkg::M_USER_BITS-1:0]    m_tuser
);
	import cbsm_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t                      state_q;
	logic                        busy_q;
	logic [TIME_BITS-1:0]        since_q;
	logic [TIME_BITS-1:0]        total_q;
	logic signed [SUM_BITS-1:0]  sum_q;
	logic signed [DB_BITS-1:0]   min_q;
	logic [COUNT_BITS-1:0]       cnt_q;

	logic                        usat_q;
	logic                        neg_q;
	logic                        svalid_q;
	logic signed [DB_BITS-1:0]   wmin_q;

	logic                        m_valid_q;
	logic [UTIL_BITS-1:0]        util_q;
	logic [DB_BITS-1:0]          mean_q;
	logic [DB_BITS-1:0]          minout_q;
	logic                        vout_q;

	logic [TIME_BITS-1:0]        elapsed;
	logic [TIME_BITS:0]          tsum;
	logic [TIME_BITS-1:0]        added;
	logic [TIME_BITS-1:0]        accum;
	logic [SUM_BITS:0]           ssum;
	logic signed [SUM_BITS-1:0]  sum_next;
	logic [SUM_BITS-1:0]         mag;
	logic                        out_free;
	logic                        result_load;
	logic                        div_start;
	logic                        ubusy;
	logic                        mbusy;
	logic [DIV_BITS-1:0]         uquo;
	logic [DIV_BITS-1:0]         mquo;
	logic [DB_BITS-1:0]          mq;

	always_comb begin
		elapsed = item.now_time - since_q;
		tsum    = {1'b0, total_q} + {1'b0, elapsed};
		added   = tsum[TIME_BITS] ? '1 : tsum[TIME_BITS-1:0];
		accum   = busy_q ? added : total_q;
		ssum    = {sum_q[SUM_BITS-1], sum_q} + (SUM_BITS+1)'(item.db);
		// saturate at the signed 32-bit limits
		if (ssum[SUM_BITS] != ssum[SUM_BITS-1])
			sum_next = ssum[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
			                          : {1'b0, {(SUM_BITS-1){1'b1}}};
		else
			sum_next = ssum[SUM_BITS-1:0];
		mag = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
		mq  = mquo[DB_BITS-1:0];
	end

	assign pop         = (state_q == ST_IDLE) && !qstat.empty;
	assign div_start   = pop && (item.kind == KIND_WEND);
	assign out_free    = !m_valid_q || m_tready;
	assign result_load = (state_q == ST_DIV) && !ubusy && !mbusy && out_free;

	cbsm_div u_util_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({WLEN_BITS'(accum), {FRAC_BITS{1'b0}}}),
		.divisor  (wlen),
		.busy     (ubusy),
		.quotient (uquo)
	);

	cbsm_div u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({{(DIV_BITS-SUM_BITS){1'b0}}, mag}),
		.divisor  ({{(DEN_BITS-COUNT_BITS){1'b0}}, cnt_q}),
		.busy     (mbusy),
		.quotient (mquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			busy_q    <= 1'b0;
			since_q   <= '0;
			total_q   <= '0;
			sum_q     <= '0;
			min_q     <= DB_INF;
			cnt_q     <= '0;
			usat_q    <= 1'b0;
			neg_q     <= 1'b0;
			svalid_q  <= 1'b0;
			wmin_q    <= '0;
			m_valid_q <= 1'b0;
			util_q    <= '0;
			mean_q    <= '0;
			minout_q  <= '0;
			vout_q    <= 1'b0;
		end else begin
			if (result_load)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (item.kind)
							KIND_BUSY: begin
								if (item.busy_level && !busy_q) begin
									since_q <= item.now_time;
									busy_q  <= 1'b1;
								end else if (!item.busy_level && busy_q) begin
									total_q <= added;
									busy_q  <= 1'b0;
								end
							end
							KIND_SINR: begin
								if ($signed(item.db) < min_q)
									min_q <= item.db;
								if (cnt_q != COUNT_MAX) begin
									sum_q <= sum_next;
									cnt_q <= cnt_q + 1'b1;
								end
							end
							KIND_WEND: begin
								usat_q   <= accum >= TIME_BITS'(wlen);
								neg_q    <= sum_q[SUM_BITS-1];
								svalid_q <= cnt_q != '0;
								wmin_q   <= min_q;
								total_q  <= '0;
								if (busy_q)
									since_q <= item.now_time;
								sum_q    <= '0;
								min_q    <= DB_INF;
								cnt_q    <= '0;
								state_q  <= ST_DIV;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (result_load) begin
						util_q    <= usat_q ? UTIL_FULL : {1'b0, uquo[FRAC_BITS-1:0]};
						mean_q    <= !svalid_q ? '0 : (neg_q ? DB_BITS'(-mq) : mq);
						minout_q  <= svalid_q ? wmin_q : '0;
						vout_q    <= svalid_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// tdata: utilization, sinr_mean_db, sinr_min_db; tuser: sinr_valid
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_BITS-UTIL_BITS-2*DB_BITS){1'b0}}, minout_q, mean_q, util_q};
	assign m_tuser  = vout_q;

	a_div_only_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(ubusy || mbusy) |-> state_q == ST_DIV)
		else $error("divider running outside window end");

	a_window_clears: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> cnt_q == '0 && min_q == DB_INF && total_q == '0 && sum_q == '0)
		else $error("window statistics not cleared at window end");

	a_util_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> util_q <= UTIL_FULL)
		else $error("utilization beyond full scale");

endmodule

`default_nettype wire

>>> rtl/channel_busy_and_sinr_window_monitor_top.sv
// top level of the channel busy and sinr window monitor
// depends on cbsm_pkg, cbsm_front, cbsm_queue, cbsm_back (and cbsm_div below it)
`default_nettype none

// usage
//  - input stream s_*: one beat per event; tuser carries the action (busy level
//    change, sinr sample or window end), tdata the time, level and linear sinr
//  - output stream m_*: one beat per window end with utilization (q1.16, 65536 is
//    fully busy), mean and minimum sinr in db (signed q8.8) and sinr_valid in tuser
//  - apb port: register 0 at byte address 0 is the window length in ticks; the user
//    must write it only while the block is idle; the block does not enforce this
//  - path: busy changes and samples pass the 3 front stages and the queue and
//    are then absorbed by the back end; a window end gives its result once the
//    two 48-step restoring dividers that run side by side in the back end are
//    done
//  - throughput: one beat per cycle into the front pipe while s_tready is high;
//    the back end takes one busy change or sample per cycle, none while dividing
//  - ignored beats (unused action, zero sinr) are taken and dropped
//  - a 4-deep queue parts front from back, so beats keep flowing while a window
//    end divides; when it fills, s_tready drops
//  - a result waits in the output register while m_tready is low; the back end
//    holds its next window end until that register is taken
//  - reset clears the control and window state at once: idle channel, empty window,
//    minimum at +infinity, window length 1000000
module channel_busy_and_sinr_window_monitor_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// s_tdata: now_time [47:0], busy_level [48], linear_sinr [80:49], zero pad
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [cbsm_pkg::S_DATA_BITS-1:0]   s_tdata,
	// s_tuser: action [1:0]
	input  wire logic [cbsm_pkg::S_USER_BITS-1:0]   s_tuser,
	// m_tdata: utilization [16:0], sinr_mean_db [32:17], sinr_min_db [48:33], zero pad
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [cbsm_pkg::M_DATA_BITS-1:0]        m_tdata,
	// m_tuser: sinr_valid [0]
	output logic [cbsm_pkg::M_USER_BITS-1:0]        m_tuser,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [cbsm_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [cbsm_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [cbsm_pkg::APB_DATA_BITS-1:0]      prdata,
	output logic                                    pready
);
	import cbsm_pkg::*;

	logic [WLEN_BITS-1:0] wlen_q;
	logic                 cfg_wr;
	logic                 push;
	logic                 pop;
	item_t                fr_item;
	item_t                bk_item;
	qstat_t               qstat;

	// configuration register, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wlen_q <= WLEN_RESET;
		else if (cfg_wr && paddr[APB_ADDR_BITS-1] == REG_WLEN)
			wlen_q <= pwdata[WLEN_BITS-1:0];
	end

	assign prdata = (paddr[APB_ADDR_BITS-1] == REG_WLEN) ? APB_DATA_BITS'(wlen_q) : '0;

	// classify beats and convert samples to db
	cbsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.qstat    (qstat),
		.push     (push),
		.item     (fr_item)
	);

	// decoupling queue
	cbsm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (fr_item),
		.pop     (pop),
		.rd_item (bk_item),
		.qstat   (qstat)
	);

	// window state, division and result register
	cbsm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wlen     (wlen_q),
		.item     (bk_item),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
